@@ rtl/core/amixb_pkg.sv @@
// ----------------------------------------------------------------------------
// Mix bus accumulator package
// Shared constants, command codes, queue sizing and the accumulator
// saturation helper.
// ----------------------------------------------------------------------------
package amixb_pkg;

  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;

  localparam int FI_W      = 10;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 14;
  localparam int ROUND_BIAS = 8192;
  localparam int MOD_SHIFT = 20;
  localparam int ACC_W     = 32;

  localparam longint ACC_MAX = 64'sd2147483647;
  localparam longint ACC_MIN = -64'sd2147483648;

  localparam logic CMD_MIX  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic is_read;
    logic last;
  } cmd_ctl_t;

  function automatic logic signed [ACC_W-1:0] sat_acc(input longint v);
    logic signed [ACC_W-1:0] res;
    if (v > ACC_MAX) begin
      res = ACC_W'(ACC_MAX);
    end else if (v < ACC_MIN) begin
      res = ACC_W'(ACC_MIN);
    end else begin
      res = ACC_W'(v);
    end
    return res;
  endfunction

endpackage

@@ rtl/core/amixb_fifo.sv @@
// ----------------------------------------------------------------------------
// Mix bus word queue
// Small first-in first-out queue of fixed depth; the caller never pushes
// into a full queue or pops an empty one.
// ----------------------------------------------------------------------------
module amixb_fifo #(
  parameter int W = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [W-1:0]                 wdata,
  input  logic                         pop,
  output logic [W-1:0]                 rdata,
  output logic [amixb_pkg::Q_CNT_W-1:0] cnt
);
  import amixb_pkg::*;

  logic [W-1:0]       mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign cnt   = cnt_r;

endmodule

@@ rtl/core/amixb_front.sv @@
// ----------------------------------------------------------------------------
// Mix bus front end
// Accepts a word, applies the gain with a registered multiply, then rounds,
// saturates and folds the frame index into the buffer range.
// ----------------------------------------------------------------------------
module amixb_front #(
  parameter int BUF_FRAMES  = 1024,
  parameter int SAMPLE_BITS = 24,
  localparam int AW = $clog2(BUF_FRAMES)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  logic                               cfg_stereo,
  input  logic                               in_cmd,
  input  logic [amixb_pkg::FI_W-1:0]         in_frame_index,
  input  logic signed [SAMPLE_BITS-1:0]      in_left,
  input  logic signed [SAMPLE_BITS-1:0]      in_right,
  input  logic                               in_stereo,
  input  logic [amixb_pkg::GAIN_W-1:0]       in_gain,
  input  logic                               in_last_frame,
  output logic                               push,
  output amixb_pkg::cmd_ctl_t                ctl,
  output logic [AW-1:0]                      idx,
  output logic signed [amixb_pkg::ACC_W-1:0] val_l,
  output logic signed [amixb_pkg::ACC_W-1:0] val_r
);
  import amixb_pkg::*;

  localparam int XW      = SAMPLE_BITS + 1;
  localparam int PW      = XW + GAIN_W + 1;
  localparam int TW      = PW + 1 - GAIN_FRAC;
  localparam int QPW     = FI_W + MOD_SHIFT;
  localparam int MOD_MUL = (1 << MOD_SHIFT) / BUF_FRAMES;
  localparam int RW      = FI_W + AW + 1;

  logic signed [XW-1:0]     xa, xb;
  logic signed [GAIN_W:0]   g;
  logic signed [PW-1:0]     pa_nxt, pb_nxt, pa_r, pb_r;
  logic [QPW-1:0]           qprod;
  logic [FI_W-1:0]          q_nxt, q_r, fi_r;
  logic                     f1_valid_r;
  cmd_ctl_t                 ctl_r;
  logic [RW-1:0]            qb, rem, rem_c;
  logic signed [PW:0]       sa, sb;
  logic signed [TW-1:0]     ta, tb;

  always_comb begin
    xa = (!cfg_stereo && in_stereo) ? XW'(in_left) + XW'(in_right) : XW'(in_left);
    xb = in_stereo ? XW'(in_right) : XW'(in_left);
    g  = $signed({1'b0, in_gain});
    pa_nxt = PW'(xa) * PW'(g);
    pb_nxt = PW'(xb) * PW'(g);
    qprod  = QPW'(in_frame_index) * QPW'(MOD_MUL);
    q_nxt  = qprod[QPW-1:MOD_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl_r.is_read <= (in_cmd == CMD_READ);
      ctl_r.last    <= in_last_frame;
      fi_r          <= in_frame_index;
      q_r           <= q_nxt;
      pa_r          <= pa_nxt;
      pb_r          <= pb_nxt;
    end
  end

  // The quotient estimate is low by at most one, so one correction suffices.
  always_comb begin
    qb    = RW'(q_r) * RW'(BUF_FRAMES);
    rem   = RW'(fi_r) - qb;
    rem_c = (rem >= RW'(BUF_FRAMES)) ? rem - RW'(BUF_FRAMES) : rem;
    idx   = rem_c[AW-1:0];
  end

  always_comb begin
    sa    = $signed({pa_r[PW-1], pa_r}) + (PW+1)'(ROUND_BIAS);
    sb    = $signed({pb_r[PW-1], pb_r}) + (PW+1)'(ROUND_BIAS);
    ta    = $signed(sa[PW:GAIN_FRAC]);
    tb    = $signed(sb[PW:GAIN_FRAC]);
    val_l = sat_acc(64'(ta));
    val_r = sat_acc(64'(tb));
  end

  assign push = f1_valid_r;
  assign ctl  = ctl_r;

endmodule

@@ rtl/core/amixb_back.sv @@
// ----------------------------------------------------------------------------
// Mix bus back end
// Reads the frame buffer, accumulates or overwrites mix words, and produces
// readout words with the mixed-state flags.
// ----------------------------------------------------------------------------
module amixb_back #(
  parameter int BUF_FRAMES  = 1024,
  parameter int SAMPLE_BITS = 24,
  localparam int AW = $clog2(BUF_FRAMES)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_stereo,
  input  logic                               q_avail,
  input  amixb_pkg::cmd_ctl_t                q_ctl,
  input  logic [AW-1:0]                      q_idx,
  input  logic signed [amixb_pkg::ACC_W-1:0] q_val_l,
  input  logic signed [amixb_pkg::ACC_W-1:0] q_val_r,
  output logic                               q_pop,
  input  logic                               out_space,
  output logic                               out_push,
  output logic signed [SAMPLE_BITS-1:0]      out_left,
  output logic signed [SAMPLE_BITS-1:0]      out_right,
  output logic                               out_has_mix,
  output logic                               out_last
);
  import amixb_pkg::*;

  localparam longint SMAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam longint SMIN = -SMAX - 64'sd1;

  logic signed [ACC_W-1:0] mix_left_r  [BUF_FRAMES];
  logic signed [ACC_W-1:0] mix_right_r [BUF_FRAMES];
  logic signed [ACC_W-1:0] rd_l_r, rd_r_r;

  logic                    y_valid_r, y_valid_nxt;
  cmd_ctl_t                y_ctl_r;
  logic [AW-1:0]           y_idx_r;
  logic signed [ACC_W-1:0] y_val_l_r, y_val_r_r;

  logic                    byp_l_v_r, byp_r_v_r;
  logic [AW-1:0]           byp_l_idx_r, byp_r_idx_r;
  logic signed [ACC_W-1:0] byp_l_val_r, byp_r_val_r;

  logic                    any_r, any_nxt, first_r, first_nxt;
  logic                    y_done, issue, wr_l, wr_r;
  logic signed [ACC_W-1:0] old_l, old_r, new_l, new_r;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input logic signed [ACC_W-1:0] v);
    longint e;
    logic signed [SAMPLE_BITS-1:0] res;
    e = 64'(v);
    if (e > SMAX) begin
      res = SAMPLE_BITS'(SMAX);
    end else if (e < SMIN) begin
      res = SAMPLE_BITS'(SMIN);
    end else begin
      res = SAMPLE_BITS'(e);
    end
    return res;
  endfunction

  // A write at the edge that loads the read data is picked up from the bypass.
  always_comb begin
    y_done = y_valid_r && (!y_ctl_r.is_read || out_space);
    issue  = q_avail && (!y_valid_r || y_done);
    old_l  = (byp_l_v_r && byp_l_idx_r == y_idx_r) ? byp_l_val_r : rd_l_r;
    old_r  = (byp_r_v_r && byp_r_idx_r == y_idx_r) ? byp_r_val_r : rd_r_r;
    new_l  = first_r ? y_val_l_r : sat_acc(64'(old_l) + 64'(y_val_l_r));
    new_r  = first_r ? y_val_r_r : sat_acc(64'(old_r) + 64'(y_val_r_r));
    wr_l   = y_done && !y_ctl_r.is_read;
    wr_r   = wr_l && cfg_stereo;

    y_valid_nxt = issue ? 1'b1 : (y_done ? 1'b0 : y_valid_r);

    any_nxt   = any_r;
    first_nxt = first_r;
    if (wr_l) begin
      any_nxt = 1'b1;
      if (y_ctl_r.last) begin
        first_nxt = 1'b0;
      end
    end else if (y_done && y_ctl_r.last) begin
      any_nxt   = 1'b0;
      first_nxt = 1'b1;
    end
  end

  assign q_pop       = issue;
  assign out_push    = y_done && y_ctl_r.is_read;
  assign out_left    = any_r ? sat_smp(old_l) : '0;
  assign out_right   = (any_r && cfg_stereo) ? sat_smp(old_r) : '0;
  assign out_has_mix = any_r;
  assign out_last    = y_ctl_r.last;

  always_ff @(posedge clk) begin
    if (wr_l) begin
      mix_left_r[y_idx_r] <= new_l;
    end
    if (issue) begin
      rd_l_r <= mix_left_r[q_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_r) begin
      mix_right_r[y_idx_r] <= new_r;
    end
    if (issue) begin
      rd_r_r <= mix_right_r[q_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_valid_r <= 1'b0;
      byp_l_v_r <= 1'b0;
      byp_r_v_r <= 1'b0;
      any_r     <= 1'b0;
      first_r   <= 1'b1;
    end else begin
      y_valid_r <= y_valid_nxt;
      any_r     <= any_nxt;
      first_r   <= first_nxt;
      if (wr_l) begin
        byp_l_v_r <= 1'b1;
      end
      if (wr_r) begin
        byp_r_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      y_ctl_r   <= q_ctl;
      y_idx_r   <= q_idx;
      y_val_l_r <= q_val_l;
      y_val_r_r <= q_val_r;
    end
    if (wr_l) begin
      byp_l_idx_r <= y_idx_r;
      byp_l_val_r <= new_l;
    end
    if (wr_r) begin
      byp_r_idx_r <= y_idx_r;
      byp_r_val_r <= new_r;
    end
  end

endmodule

@@ rtl/core/audio_mix_bus_accumulator.sv @@
// ----------------------------------------------------------------------------
// Audio mix bus accumulator
// Mixes gain-scaled audio frames from several inputs into one frame buffer
// and reads the mixed frames back, in mono or stereo bus format.
// ----------------------------------------------------------------------------
// The input channel takes a word when push is high and full is low. A mix
// word (in_cmd low) scales one frame by in_gain and overwrites or adds into
// the buffer entry at in_frame_index; it gives no result. A read word gives
// one result word on the out_ ports while empty is low, taken with pop.
// Words are carried out in order; one word a cycle is sustained on both
// sides. A read word passes the gain multiply stage, command queue, buffer
// read stage and result queue on its way to the result ports. The buffer is
// one 32-bit memory per bus channel with one write and one read port, and a
// write-to-read bypass keeps back-to-back words on the same frame exact. When
// the receiver stalls, the result queue fills, the back end holds its read
// word, the command queue fills behind it and full rises. Reset empties both
// queues and clears the mixed state but not the buffer. cfg_wdata sets the bus
// format; the user must write it only while idle (the block does not check).
// ----------------------------------------------------------------------------
module audio_mix_bus_accumulator #(
  parameter int BUF_FRAMES  = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_wdata,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_cmd,
  input  logic [amixb_pkg::FI_W-1:0]   in_frame_index,
  input  logic signed [SAMPLE_BITS-1:0] in_left,
  input  logic signed [SAMPLE_BITS-1:0] in_right,
  input  logic                         in_stereo,
  input  logic [amixb_pkg::GAIN_W-1:0] in_gain,
  input  logic                         in_last_frame,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right,
  output logic                         out_has_mix,
  output logic                         out_last
);
  import amixb_pkg::*;

  localparam int AW = $clog2(BUF_FRAMES);
  localparam int CW = 2 + AW + 2 * ACC_W;
  localparam int OW = 2 + 2 * SAMPLE_BITS;

  logic                    out_stereo_r;
  logic                    accept;
  logic                    f1_push;
  cmd_ctl_t                f_ctl, q_ctl;
  logic [AW-1:0]           f_idx, q_idx;
  logic signed [ACC_W-1:0] f_val_l, f_val_r, q_val_l, q_val_r;
  logic [CW-1:0]           cmdq_wdata, cmdq_rdata;
  logic [Q_CNT_W-1:0]      cmdq_cnt, out_cnt;
  logic                    cmdq_pop;
  logic                    b_out_push, b_has_mix, b_last;
  logic signed [SAMPLE_BITS-1:0] b_left, b_right;
  logic [OW-1:0]           outq_wdata, outq_rdata;
  logic                    out_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_stereo_r <= 1'b0;
    end else if (cfg_we) begin
      out_stereo_r <= cfg_wdata;
    end
  end

  assign full   = (cmdq_cnt + Q_CNT_W'(f1_push)) >= Q_CNT_W'(Q_DEPTH);
  assign accept = push && !full;

  amixb_front #(
    .BUF_FRAMES (BUF_FRAMES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .cfg_stereo    (out_stereo_r),
    .in_cmd        (in_cmd),
    .in_frame_index(in_frame_index),
    .in_left       (in_left),
    .in_right      (in_right),
    .in_stereo     (in_stereo),
    .in_gain       (in_gain),
    .in_last_frame (in_last_frame),
    .push          (f1_push),
    .ctl           (f_ctl),
    .idx           (f_idx),
    .val_l         (f_val_l),
    .val_r         (f_val_r)
  );

  assign cmdq_wdata = {f_ctl, f_idx, f_val_l, f_val_r};
  assign {q_ctl, q_idx, q_val_l, q_val_r} = cmdq_rdata;

  amixb_fifo #(
    .W(CW)
  ) u_cmdq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (f1_push),
    .wdata(cmdq_wdata),
    .pop  (cmdq_pop),
    .rdata(cmdq_rdata),
    .cnt  (cmdq_cnt)
  );

  amixb_back #(
    .BUF_FRAMES (BUF_FRAMES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_stereo (out_stereo_r),
    .q_avail    (cmdq_cnt != '0),
    .q_ctl      (q_ctl),
    .q_idx      (q_idx),
    .q_val_l    (q_val_l),
    .q_val_r    (q_val_r),
    .q_pop      (cmdq_pop),
    .out_space  (out_cnt < Q_CNT_W'(Q_DEPTH)),
    .out_push   (b_out_push),
    .out_left   (b_left),
    .out_right  (b_right),
    .out_has_mix(b_has_mix),
    .out_last   (b_last)
  );

  assign outq_wdata = {b_has_mix, b_last, b_right, b_left};
  assign out_pop    = pop && !empty;

  amixb_fifo #(
    .W(OW)
  ) u_outq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (b_out_push),
    .wdata(outq_wdata),
    .pop  (out_pop),
    .rdata(outq_rdata),
    .cnt  (out_cnt)
  );

  assign empty = (out_cnt == '0);
  assign {out_has_mix, out_last, out_right, out_left} = outq_rdata;

`ifndef SYNTHESIS
  a_cmdq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmdq_cnt == Q_CNT_W'(Q_DEPTH)) |-> !(f1_push && !cmdq_pop))
    else $error("command queue written while full");

  a_outq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_cnt == Q_CNT_W'(Q_DEPTH)) |-> !b_out_push)
    else $error("result queue written while full");

  a_accept_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> f1_push)
    else $error("accepted word did not reach the command queue");
`endif

endmodule

@@ verif/audio_mix_bus_accumulator_tb.sv @@
// ----------------------------------------------------------------------------
// Audio mix bus accumulator testbench
// Drives mix and read words through the input queue and checks every result
// word against a cycle-free model of the frame buffer, in mono and stereo bus
// formats, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module audio_mix_bus_accumulator_tb;
  import amixb_pkg::*;

  localparam int BUF_FRAMES = 1024;
  localparam int SAMPLE_BITS = 24;
  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam int PIPE_SETTLE = 8;
  localparam int UNITY_GAIN = 1 << GAIN_FRAC;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t FULL_SCALE_POS = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam sample_t FULL_SCALE_NEG = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  typedef struct {
    logic              cmd;
    logic [FI_W-1:0]   frame;
    sample_t           left;
    sample_t           right;
    logic              stereo;
    logic [GAIN_W-1:0] gain;
    logic              last;
  } bus_word_t;

  typedef struct {
    sample_t left;
    sample_t right;
    logic    has_mix;
    logic    last;
  } mixed_frame_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              push = 1'b0;
  logic              in_cmd = 1'b0;
  logic [FI_W-1:0]   in_frame_index = '0;
  sample_t           in_left = '0;
  sample_t           in_right = '0;
  logic              in_stereo = 1'b0;
  logic [GAIN_W-1:0] in_gain = '0;
  logic              in_last_frame = 1'b0;
  logic              pop = 1'b0;
  logic              full;
  logic              empty;
  sample_t           out_left;
  sample_t           out_right;
  logic              out_has_mix;
  logic              out_last;

  logic signed [ACC_W-1:0] acc_left [BUF_FRAMES];
  logic signed [ACC_W-1:0] acc_right [BUF_FRAMES];
  bit written_left [BUF_FRAMES];
  bit written_right [BUF_FRAMES];
  int ready_mono [$];
  int ready_stereo [$];
  bit any_mixed = 1'b0;
  bit overwrite_mode = 1'b1;
  bit bus_stereo = 1'b0;
  mixed_frame_t pending_frames [$];
  int mismatches = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;

  audio_mix_bus_accumulator #(
    .BUF_FRAMES(BUF_FRAMES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .push(push),
    .full(full),
    .in_cmd(in_cmd),
    .in_frame_index(in_frame_index),
    .in_left(in_left),
    .in_right(in_right),
    .in_stereo(in_stereo),
    .in_gain(in_gain),
    .in_last_frame(in_last_frame),
    .empty(empty),
    .pop(pop),
    .out_left(out_left),
    .out_right(out_right),
    .out_has_mix(out_has_mix),
    .out_last(out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint apply_gain(longint x, logic [GAIN_W-1:0] g);
    longint p;
    p = x * longint'(g) + ROUND_BIAS;
    return clamp(p >>> GAIN_FRAC, ACC_MIN, ACC_MAX);
  endfunction

  function automatic logic signed [ACC_W-1:0] accumulate(logic signed [ACC_W-1:0] acc,
                                                         longint v);
    if (overwrite_mode) begin
      return ACC_W'(v);
    end
    return ACC_W'(clamp(longint'(acc) + v, ACC_MIN, ACC_MAX));
  endfunction

  function automatic void mark_written(int i, bit both);
    if (!written_left[i]) begin
      written_left[i] = 1'b1;
      ready_mono = {ready_mono, i};
    end
    if (both && !written_right[i]) begin
      written_right[i] = 1'b1;
      ready_stereo = {ready_stereo, i};
    end
  endfunction

  // A stereo entry is only ever written together with its left half.
  function automatic bit entry_ready(int i);
    return bus_stereo ? written_right[i] : written_left[i];
  endfunction

  function automatic int ready_count();
    return bus_stereo ? ready_stereo.size() : ready_mono.size();
  endfunction

  function automatic int pick_ready();
    if (bus_stereo) begin
      return ready_stereo[$urandom_range(ready_stereo.size() - 1)];
    end
    return ready_mono[$urandom_range(ready_mono.size() - 1)];
  endfunction

  task automatic predict_mix_bus(input bus_word_t w);
    longint a;
    longint b;
    mixed_frame_t f;
    int i;
    i = int'(w.frame) % BUF_FRAMES;
    if (w.cmd == CMD_MIX) begin
      if (bus_stereo) begin
        a = apply_gain(longint'(w.left), w.gain);
        b = w.stereo ? apply_gain(longint'(w.right), w.gain) : a;
        acc_left[i] = accumulate(acc_left[i], a);
        acc_right[i] = accumulate(acc_right[i], b);
        mark_written(i, 1'b1);
      end else begin
        a = apply_gain(w.stereo ? longint'(w.left) + longint'(w.right) : longint'(w.left),
                       w.gain);
        acc_left[i] = accumulate(acc_left[i], a);
        mark_written(i, 1'b0);
      end
      any_mixed = 1'b1;
      if (w.last) begin
        overwrite_mode = 1'b0;
      end
    end else begin
      f.left = '0;
      f.right = '0;
      if (any_mixed) begin
        f.left = sample_t'(clamp(longint'(acc_left[i]), SAMPLE_MIN, SAMPLE_MAX));
        if (bus_stereo) begin
          f.right = sample_t'(clamp(longint'(acc_right[i]), SAMPLE_MIN, SAMPLE_MAX));
        end
      end
      f.has_mix = any_mixed;
      f.last = w.last;
      pending_frames = {pending_frames, f};
      if (w.last) begin
        any_mixed = 1'b0;
        overwrite_mode = 1'b1;
      end
    end
  endtask

  function automatic void check_field(string name, sample_t expected, sample_t actual);
    if (actual !== expected) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    mixed_frame_t exp_f;
    if (rst_n && pop && !empty) begin
      if (pending_frames.size() == 0) begin
        $error("result word with no read word outstanding");
        mismatches++;
      end else begin
        exp_f = pending_frames.pop_front();
        check_field("out_left", exp_f.left, out_left);
        check_field("out_right", exp_f.right, out_right);
        check_field("out_has_mix", sample_t'(exp_f.has_mix), sample_t'(out_has_mix));
        check_field("out_last", sample_t'(exp_f.last), sample_t'(out_last));
      end
    end
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // Words that would read or add onto a never-written entry are steered to a
  // written one, or turned into an overwriting mix when none exists yet.
  task automatic send_word(input bus_word_t w);
    if ((w.cmd == CMD_READ || !overwrite_mode) && !entry_ready(int'(w.frame))) begin
      if (ready_count() > 0) begin
        w.frame = FI_W'(pick_ready());
      end else begin
        w.cmd = CMD_MIX;
      end
    end
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_cmd <= w.cmd;
    in_frame_index <= w.frame;
    in_left <= w.left;
    in_right <= w.right;
    in_stereo <= w.stereo;
    in_gain <= w.gain;
    in_last_frame <= w.last;
    do @(posedge clk); while (full);
    predict_mix_bus(w);
    words_sent++;
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() > 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic set_bus_format(input bit st);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= st;
    @(posedge clk);
    cfg_we <= 1'b0;
    bus_stereo = st;
  endtask

  function automatic bus_word_t mix_word(int frame, sample_t l, sample_t r, bit st,
                                         logic [GAIN_W-1:0] g, bit last);
    bus_word_t w;
    w.cmd = CMD_MIX;
    w.frame = FI_W'(frame);
    w.left = l;
    w.right = r;
    w.stereo = st;
    w.gain = g;
    w.last = last;
    return w;
  endfunction

  function automatic bus_word_t read_word(int frame, bit last);
    bus_word_t w;
    w = mix_word(frame, '0, '0, 1'b0, '0, last);
    w.cmd = CMD_READ;
    return w;
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(9))
      0: return FULL_SCALE_POS;
      1: return FULL_SCALE_NEG;
      2: return '0;
      3: return sample_t'(int'($urandom_range(64)) - 32);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(9))
      0: return GAIN_W'(UNITY_GAIN);
      1: return '0;
      2: return '1;
      3: return GAIN_W'($urandom_range(2 * UNITY_GAIN));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic bus_word_t random_word();
    bus_word_t w;
    w.cmd = 1'($urandom_range(1));
    w.frame = FI_W'($urandom);
    w.left = random_sample();
    w.right = random_sample();
    w.stereo = 1'($urandom_range(1));
    w.gain = random_gain();
    w.last = ($urandom_range(3) == 0);
    return w;
  endfunction

  task automatic end_readout();
    bus_word_t w;
    w = random_word();
    w.cmd = CMD_READ;
    w.last = 1'b1;
    send_word(w);
  endtask

  // One to four inputs mix into a run of frames, then the run is read back.
  task automatic play_block();
    int base;
    int nframes;
    int ninputs;
    bit st;
    bit fits;
    logic [GAIN_W-1:0] g;
    bus_word_t w;
    base = $urandom_range(BUF_FRAMES - 1);
    nframes = ($urandom_range(9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
    if (!overwrite_mode) begin
      fits = 1'b1;
      for (int f = 0; f < nframes; f++) begin
        if (!entry_ready((base + f) % BUF_FRAMES)) fits = 1'b0;
      end
      if (!fits) begin
        base = pick_ready();
        nframes = 1;
      end
    end
    ninputs = $urandom_range(1, 4);
    for (int k = 0; k < ninputs; k++) begin
      st = 1'($urandom_range(1));
      g = random_gain();
      for (int f = 0; f < nframes; f++) begin
        send_word(mix_word((base + f) % BUF_FRAMES, random_sample(), random_sample(), st, g,
                           f == nframes - 1));
      end
    end
    for (int f = 0; f < nframes; f++) begin
      w = random_word();
      w.cmd = CMD_READ;
      w.frame = FI_W'((base + f) % BUF_FRAMES);
      w.last = (f == nframes - 1) && ($urandom_range(9) != 0);
      send_word(w);
    end
  endtask

  // Full-scale inputs drive one entry into positive saturation and then back
  // down, so that a wrapping accumulator would show on the readout.
  task automatic saturation_ramp();
    int idx;
    int rises;
    int falls;
    bus_word_t w;
    idx = overwrite_mode ? $urandom_range(BUF_FRAMES - 1) : pick_ready();
    rises = bus_stereo ? 68 : 36;
    falls = $urandom_range(rises / 2, rises + 8);
    for (int k = 0; k < rises + falls; k++) begin
      w = mix_word(idx, (k < rises) ? FULL_SCALE_POS : FULL_SCALE_NEG,
                   (k < rises) ? FULL_SCALE_POS : FULL_SCALE_NEG, 1'b1, '1, 1'b1);
      send_word(w);
    end
    send_word(read_word(idx, 1'b1));
  endtask

  task automatic run_phase(input bit st, input int idle, input int stall, input int nwords);
    int stop;
    int pick;
    if (st && !overwrite_mode && ready_stereo.size() == 0) begin
      end_readout();
    end
    set_bus_format(st);
    send_idle_pct = idle;
    pop_stall_pct = stall;
    stop = words_sent + nwords;
    while (words_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        play_block();
      end else if (pick < 75) begin
        saturation_ramp();
      end else begin
        repeat ($urandom_range(1, 8)) send_word(random_word());
      end
    end
  endtask

  task automatic test_mono_bus_extremes();
    set_bus_format(1'b0);
    send_word(mix_word(0, FULL_SCALE_POS, FULL_SCALE_POS, 1'b1, '1, 1'b0));
    send_word(mix_word(1023, FULL_SCALE_NEG, FULL_SCALE_NEG, 1'b1, '1, 1'b1));
    send_word(mix_word(0, FULL_SCALE_NEG, FULL_SCALE_POS, 1'b0, '0, 1'b0));
    send_word(mix_word(1023, -1, 0, 1'b0, 1, 1'b0));
    send_word(mix_word(0, 1, 0, 1'b0, GAIN_W'(UNITY_GAIN / 2), 1'b0));
    send_word(mix_word(1023, -3, 0, 1'b0, GAIN_W'(UNITY_GAIN / 2), 1'b0));
    send_word(read_word(0, 1'b0));
    send_word(read_word(1023, 1'b1));
    send_word(read_word(0, 1'b0));
    send_word(mix_word(7, 100, -100, 1'b0, GAIN_W'(UNITY_GAIN), 1'b1));
    send_word(read_word(7, 1'b1));
  endtask

  task automatic test_stereo_bus();
    set_bus_format(1'b1);
    send_word(mix_word(5, 1234567, -1, 1'b0, GAIN_W'(UNITY_GAIN), 1'b0));
    send_word(mix_word(6, -5, 777, 1'b1, 20000, 1'b1));
    send_word(mix_word(5, FULL_SCALE_POS, FULL_SCALE_NEG, 1'b1, GAIN_W'(UNITY_GAIN), 1'b0));
    send_word(read_word(5, 1'b0));
    send_word(read_word(6, 1'b1));
  endtask

  task automatic test_format_change();
    send_word(mix_word(9, 1000, -2000, 1'b1, GAIN_W'(UNITY_GAIN), 1'b1));
    set_bus_format(1'b0);
    send_word(mix_word(9, 50, 60, 1'b1, GAIN_W'(UNITY_GAIN), 1'b0));
    send_word(read_word(9, 1'b1));
    send_word(mix_word(9, 7, 0, 1'b0, GAIN_W'(UNITY_GAIN), 1'b1));
    set_bus_format(1'b1);
    send_word(mix_word(9, 1, 2, 1'b1, GAIN_W'(UNITY_GAIN), 1'b0));
    send_word(read_word(9, 1'b1));
  endtask

  task automatic test_accumulator_saturation();
    set_bus_format(1'b0);
    saturation_ramp();
    set_bus_format(1'b1);
    saturation_ramp();
  endtask

  task automatic test_random_mixing();
    run_phase(1'b0, 0, 0, 240);
    run_phase(1'b1, 0, 0, 240);
    run_phase(1'b0, 58, 0, 240);
    run_phase(1'b1, 58, 0, 240);
    run_phase(1'b1, 0, 58, 240);
    run_phase(1'b0, 0, 58, 240);
    run_phase(1'b1, 35, 35, 240);
    run_phase(1'b0, 35, 35, 240);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_mono_bus_extremes();
    test_stereo_bus();
    test_format_change();
    test_accumulator_saturation();
    test_random_mixing();
    wait_idle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
